// ===== src/decimal_string_formatter_macros.svh =====
// assertion macros used by the decimal formatter rtl
`ifndef DECIMAL_STRING_FORMATTER_MACROS_SVH
`define DECIMAL_STRING_FORMATTER_MACROS_SVH

// condition implies consequence in the same cycle
`define DSF_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define DSF_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dsf_pkg.sv =====
// package of constants and types for the decimal formatter
`default_nettype none
package dsf_pkg;

  localparam int MAX_DIGITS = 10;
  localparam int VALUE_BITS = 32;
  localparam int BCD_W      = 4 * MAX_DIGITS;
  localparam int BIT_CNT_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int DCNT_W     = $clog2(MAX_DIGITS + 1);

  localparam logic [5:0] CHAR_ZERO = 6'd48;
  localparam logic [5:0] CHAR_NINE = 6'd57;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } dsf_state_t;

  typedef struct packed {
    logic load;
    logic digit_shift;
  } dsf_cmd_t;

  typedef struct packed {
    logic       conv_done;
    logic [3:0] top_digit;
  } dsf_sts_t;

endpackage
`default_nettype wire

// ===== src/dsf_dabble.sv =====
// bit-serial shift-and-add-3 binary to bcd converter with digit shift-out
`default_nettype none
module dsf_dabble
  import dsf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dsf_cmd_t              cmd,
  input  wire logic [VALUE_BITS-1:0] value,
  output dsf_sts_t                   sts
);

  logic [VALUE_BITS-1:0] value_r, value_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [BCD_W-1:0]      bcd_adj;
  logic [BIT_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;

  // add 3 to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    value_nxt = value_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (cmd.load) begin
      value_nxt = value;
      bcd_nxt   = '0;
      cnt_nxt   = '0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      bcd_nxt   = {bcd_adj[BCD_W-2:0], value_r[VALUE_BITS-1]};
      value_nxt = value_r << 1;
      cnt_nxt   = cnt_r + 1'b1;
      if (cnt_r == BIT_CNT_W'(VALUE_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (cmd.digit_shift) begin
      bcd_nxt = bcd_r << 4;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    bcd_r   <= bcd_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.conv_done = done_r;
  assign sts.top_digit = bcd_r[BCD_W-1 -: 4];

endmodule
`default_nettype wire

// ===== src/decimal_string_formatter.sv =====
// after acceptance a value is converted serially, its leading zeros are skipped, then its digits are emitted
// a new value is accepted only in idle, once every digit of the previous value has been emitted
// digits leave one per cycle through the output register while out_ready holds; a new value is
// taken while the final digit still waits there
// reset: synchronous active-low rst_n clears the sequencer, counters and output valid
// top level of the decimal formatter: sequencer and output register
`default_nettype none
`include "decimal_string_formatter_macros.svh"
module decimal_string_formatter
  import dsf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [VALUE_BITS-1:0] in_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [5:0]                 out_digit_char,
  output logic                       out_last
);

  dsf_state_t        state_r, state_nxt;
  logic [DCNT_W-1:0] rem_r, rem_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [5:0]        out_digit_char_r;
  logic              out_last_r;
  logic              emit;
  dsf_cmd_t          cmd;
  dsf_sts_t          sts;

  dsf_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .value (in_value),
    .sts   (sts)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (sts.conv_done) state_nxt = ST_SKIP;
      end
      ST_SKIP: begin
        if (sts.top_digit != 4'd0 || rem_r == DCNT_W'(1)) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if ((!out_valid_r || out_ready) && rem_r == DCNT_W'(1)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready        = 1'b0;
    cmd.load        = 1'b0;
    cmd.digit_shift = 1'b0;
    emit            = 1'b0;
    rem_nxt         = rem_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        rem_nxt  = DCNT_W'(MAX_DIGITS);
      end
      ST_CONV: begin
      end
      ST_SKIP: begin
        // drop leading zeros but always keep the units digit
        if (sts.top_digit == 4'd0 && rem_r != DCNT_W'(1)) begin
          cmd.digit_shift = 1'b1;
          rem_nxt         = rem_r - 1'b1;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          emit            = 1'b1;
          cmd.digit_shift = 1'b1;
          rem_nxt         = rem_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_digit_char_r <= CHAR_ZERO + {2'b00, sts.top_digit};
      out_last_r       <= (rem_r == DCNT_W'(1));
    end
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_digit_char_r;
  assign out_last       = out_last_r;

  `DSF_ASSERT_NEXT(a_accept_starts_conv, in_valid && in_ready, state_r == ST_CONV, "request not converted")
  `DSF_ASSERT_NOW(a_mid_run_in_emit, out_valid_r && !out_last_r, state_r == ST_EMIT, "digit run cut short")
  `DSF_ASSERT_NOW(a_emit_has_digits, state_r == ST_EMIT, rem_r != '0, "emit with no digits left")
  `DSF_ASSERT_NOW(a_char_range, out_valid_r, out_digit_char_r >= CHAR_ZERO && out_digit_char_r <= CHAR_NINE, "digit out of range")

endmodule
`default_nettype wire
